[sv/asc_pkg.sv]
// shared types and constants for the autorange step controller
package asc_pkg;

   localparam int unsigned READING_W = 32;
   localparam int unsigned THRESH_W  = 31;
   localparam int unsigned LIMIT_W   = 16;
   localparam int unsigned COUNT_W   = 17;
   localparam int unsigned RANGE_W   = 3;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DAT_W = 32;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_AUTO_ENABLE     = 3'd0;
   localparam csr_index_type CSR_UPPER_THRESHOLD = 3'd1;
   localparam csr_index_type CSR_LOWER_THRESHOLD = 3'd2;
   localparam csr_index_type CSR_SETTLE_LIMIT    = 3'd3;
   localparam csr_index_type CSR_TOP_RANGE       = 3'd4;
   localparam csr_index_type CSR_BOTTOM_RANGE    = 3'd5;
   localparam csr_index_type CSR_INITIAL_RANGE   = 3'd6;

   localparam logic [THRESH_W-1:0] UPPER_THRESHOLD_RST = 31'd22000;
   localparam logic [THRESH_W-1:0] LOWER_THRESHOLD_RST = 31'd2000;
   localparam logic [LIMIT_W-1:0]  SETTLE_LIMIT_RST    = 16'd3;
   localparam logic [RANGE_W-1:0]  TOP_RANGE_RST       = 3'd7;
   localparam logic [RANGE_W-1:0]  BOTTOM_RANGE_RST    = 3'd0;
   localparam logic [RANGE_W-1:0]  INITIAL_RANGE_RST   = 3'd0;

   localparam logic DIR_DOWN = 1'b0;
   localparam logic DIR_UP   = 1'b1;

   typedef struct packed {
      logic                auto_enable;
      logic [THRESH_W-1:0] upper_threshold;
      logic [THRESH_W-1:0] lower_threshold;
      logic [LIMIT_W-1:0]  settle_limit;
      logic [RANGE_W-1:0]  top_range;
      logic [RANGE_W-1:0]  bottom_range;
      logic [RANGE_W-1:0]  initial_range;
   } cfg_type;

   typedef struct packed {
      logic [RANGE_W-1:0] current_range;
      logic               step_direction;
      logic [COUNT_W-1:0] settle_count;
   } state_type;

endpackage

[sv/asc_if.sv]
// word channel interfaces: readings in, range results out, register writes
interface asc_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [asc_pkg::READING_W-1:0]  reading;
   modport source (output valid, output reading, input ready);
   modport sink   (input valid, input reading, output ready);
endinterface

interface asc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [asc_pkg::RANGE_W-1:0]  range_code;
   logic                         range_changed;
   modport source (output valid, output range_code, output range_changed, input ready);
   modport sink   (input valid, input range_code, input range_changed, output ready);
endinterface

interface asc_csr_if;
   logic                          valid;
   logic                          ready;
   logic [asc_pkg::CSR_IDX_W-1:0] index;
   logic [asc_pkg::CSR_DAT_W-1:0] wdata;
   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

[sv/asc_csr_regs.sv]
// configuration register file
module asc_csr_regs (
   input  logic                          clock,
   input  logic                          reset,
   asc_csr_if.sink                       csr_port,
   output asc_pkg::cfg_type              cfg,
   output logic                          load_range
);

   asc_pkg::cfg_type cfg_ff;
   asc_pkg::cfg_type cfg_in;
   logic             wr_en;

   assign csr_port.ready = 1'b1;
   assign wr_en          = csr_port.valid;

   always_comb begin
      cfg_in     = cfg_ff;
      load_range = 1'b0;
      if (wr_en) begin
         case (csr_port.index)
            asc_pkg::CSR_AUTO_ENABLE:     cfg_in.auto_enable     = csr_port.wdata[0];
            asc_pkg::CSR_UPPER_THRESHOLD:
               cfg_in.upper_threshold = csr_port.wdata[asc_pkg::THRESH_W-1:0];
            asc_pkg::CSR_LOWER_THRESHOLD:
               cfg_in.lower_threshold = csr_port.wdata[asc_pkg::THRESH_W-1:0];
            asc_pkg::CSR_SETTLE_LIMIT:
               cfg_in.settle_limit = csr_port.wdata[asc_pkg::LIMIT_W-1:0];
            asc_pkg::CSR_TOP_RANGE:
               cfg_in.top_range = csr_port.wdata[asc_pkg::RANGE_W-1:0];
            asc_pkg::CSR_BOTTOM_RANGE:
               cfg_in.bottom_range = csr_port.wdata[asc_pkg::RANGE_W-1:0];
            asc_pkg::CSR_INITIAL_RANGE: begin
               cfg_in.initial_range = csr_port.wdata[asc_pkg::RANGE_W-1:0];
               load_range           = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.auto_enable     <= 1'b1;
         cfg_ff.upper_threshold <= asc_pkg::UPPER_THRESHOLD_RST;
         cfg_ff.lower_threshold <= asc_pkg::LOWER_THRESHOLD_RST;
         cfg_ff.settle_limit    <= asc_pkg::SETTLE_LIMIT_RST;
         cfg_ff.top_range       <= asc_pkg::TOP_RANGE_RST;
         cfg_ff.bottom_range    <= asc_pkg::BOTTOM_RANGE_RST;
         cfg_ff.initial_range   <= asc_pkg::INITIAL_RANGE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[sv/asc_step_logic.sv]
// per-reading range decision: threshold compare, settle count, bounded step
module asc_step_logic (
   input  asc_pkg::cfg_type                     cfg,
   input  asc_pkg::state_type                   state_cur,
   input  logic signed [asc_pkg::READING_W-1:0] reading,
   output asc_pkg::state_type                   state_nxt,
   output logic                                 changed
);

   logic [asc_pkg::READING_W-1:0] raw;
   logic [asc_pkg::READING_W-1:0] mag;
   logic                          above;
   logic                          below;
   logic                          dir;
   logic [asc_pkg::COUNT_W-1:0]   base;
   logic [asc_pkg::COUNT_W-1:0]   bumped;
   logic                          exceeded;

   // most negative reading wraps to 2^31 and lands above any threshold
   assign raw   = reading;
   assign mag   = raw[asc_pkg::READING_W-1] ? (~raw + 32'd1) : raw;
   assign above = mag > {1'b0, cfg.upper_threshold};
   assign below = mag < {1'b0, cfg.lower_threshold};
   assign dir   = above ? asc_pkg::DIR_UP : asc_pkg::DIR_DOWN;

   // count restarts on a direction flip
   assign base     = (state_cur.step_direction != dir) ? '0 : state_cur.settle_count;
   assign bumped   = base + 17'd1;
   assign exceeded = bumped > {1'b0, cfg.settle_limit};

   always_comb begin
      state_nxt = state_cur;
      changed   = 1'b0;
      if (cfg.auto_enable && (above || below)) begin
         state_nxt.step_direction = dir;
         state_nxt.settle_count   = exceeded ? '0 : bumped;
         if (exceeded) begin
            if (above && (state_cur.current_range < cfg.top_range)) begin
               state_nxt.current_range = state_cur.current_range + 3'd1;
               changed                 = 1'b1;
            end else if (!above && (state_cur.current_range > cfg.bottom_range)) begin
               state_nxt.current_range = state_cur.current_range - 3'd1;
               changed                 = 1'b1;
            end
         end
      end
   end

endmodule

[sv/autorange_step_controller.sv]
// top level of the autorange step controller
//
// usage:
//   req_port carries one signed reading per word (valid/ready); rsp_port returns
//   one word per reading with the range code after that reading and a flag set
//   when the reading stepped the range; csr_port writes the seven config
//   registers by index and is always ready.
// timing:
//   a reading is captured in the input register, is decided by the step
//   logic and is registered into the result register, from which it is
//   offered. while rsp ready stays high one reading is taken every cycle: the
//   input register refills in the same cycle it hands its word to the result
//   register, and the decision is a single compare/increment pass.
// reset:
//   synchronous; registers return to their defaults, range goes to the
//   initial range default, the settle count and direction clear, both
//   pipeline stages empty. no clearing pass is needed.
// stall:
//   when rsp ready is low the result holds, one more reading is buffered in
//   the input register, then req ready drops until the receiver takes a word.
// writing the initial range register loads the current range right away.
module autorange_step_controller (
   input  logic       clock,
   input  logic       reset,
   asc_req_if.sink    req_port,
   asc_rsp_if.source  rsp_port,
   asc_csr_if.sink    csr_port
);

   asc_pkg::cfg_type   cfg;
   logic               load_range;

   // input register
   logic                                  in_valid_ff;
   logic                                  in_valid_in;
   logic signed [asc_pkg::READING_W-1:0]  reading_ff;

   // range state
   asc_pkg::state_type state_ff;
   asc_pkg::state_type state_in;
   asc_pkg::state_type state_step;
   logic               step_changed;

   // result register
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic [asc_pkg::RANGE_W-1:0]   range_code_ff;
   logic                          range_changed_ff;

   logic advance;
   logic req_take;

   asc_csr_regs u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_port   (csr_port),
      .cfg        (cfg),
      .load_range (load_range)
   );

   asc_step_logic u_step (
      .cfg       (cfg),
      .state_cur (state_ff),
      .reading   (reading_ff),
      .state_nxt (state_step),
      .changed   (step_changed)
   );

   // the held word moves on when the result slot is empty or being drained
   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_port.ready);
   assign req_port.ready = !in_valid_ff || advance;
   assign req_take       = req_port.valid && req_port.ready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_port.ready);

   always_comb begin
      state_in = advance ? state_step : state_ff;
      // initial range write loads the range, count and direction are kept
      if (load_range) begin
         state_in.current_range = csr_port.wdata[asc_pkg::RANGE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff             <= 1'b0;
         rsp_valid_ff            <= 1'b0;
         state_ff.current_range  <= asc_pkg::INITIAL_RANGE_RST;
         state_ff.step_direction <= asc_pkg::DIR_DOWN;
         state_ff.settle_count   <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         reading_ff <= req_port.reading;
      end
      if (advance) begin
         range_code_ff    <= state_step.current_range;
         range_changed_ff <= step_changed;
      end
   end

   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.range_code    = range_code_ff;
   assign rsp_port.range_changed = range_changed_ff;

`ifndef SYNTHESIS
   // a word that stepped the range left the settle count cleared behind it
   a_step_clears_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && range_changed_ff |-> state_ff.settle_count == '0)
      else $error("settle count not cleared after a range step");

   // with auto ranging off no word may report a step
   a_no_step_when_off: assert property (@(posedge clock) disable iff (reset)
      advance && !cfg.auto_enable |=> !range_changed_ff)
      else $error("range step reported with auto ranging disabled");

   // the range only moves through a reported step or a register load
   a_range_moves_by_step: assert property (@(posedge clock) disable iff (reset)
      advance && !load_range |=>
         (state_ff.current_range == $past(state_ff.current_range)) || range_changed_ff)
      else $error("range moved without a reported step");

   // both stages full and stalled: no new reading may be taken
   a_full_backpressure: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && rsp_valid_ff && !rsp_port.ready |-> !req_port.ready)
      else $error("reading accepted while both stages are full");
`endif

endmodule
